// File: rtl/srfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfp_pkg: shared types and constants of the range frame parser
// Parse phase codes, status codes, register indexes, reset values and the
// word that passes from the input stage to the parse stage.
// ----------------------------------------------------------------------------
package srfp_pkg;

  localparam int DistW = 10;
  localparam int ByteW = 8;
  localparam int CfgIdxW = 8;

  // Parse phase codes
  localparam logic [1:0] PH_WAIT_R = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_CR     = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_ERR = 2'd1;
  localparam logic [1:0] ST_NEW = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_MIN_DIST = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_DIST = 8'd1;

  // Reset values
  localparam logic [DistW-1:0] RESET_DIST = 10'd20;
  localparam logic [DistW-1:0] RESET_MIN  = 10'd20;
  localparam logic [DistW-1:0] RESET_MAX  = 10'd800;

  // Frame bytes
  localparam logic [ByteW-1:0] CHAR_R    = 8'h52;
  localparam logic [ByteW-1:0] CHAR_CR   = 8'h0D;
  localparam logic [ByteW-1:0] CHAR_ZERO = 8'h30;
  localparam logic [ByteW-1:0] CHAR_NINE = 8'h39;
  localparam logic [1:0]       FRAME_DIGITS = 2'd3;

  // Word held in the input stage
  typedef struct packed {
    logic             vld;
    logic [ByteW-1:0] rx_byte;
  } srfp_item_t;

endpackage

// File: rtl/sonar_range_frame_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sonar_range_frame_parser_top: serial range frame parser
// Takes received bytes of 'R', three ASCII digits and CR frames and gives
// one status word per byte together with the last good distance in cm.
//
// Usage:
//   in_*  : one received byte per word in in_tdata[7:0].
//   out_* : one result word per input byte; status in out_tuser, last
//           valid distance in out_tdata.
//   cfg_* : register writes, index 0 min distance, 1 max distance (cm);
//           other indexes are dropped. cfg_ready is always high.
// The byte waits in the input register, and the parse stage loads the result
// register when it takes the byte. One byte is taken every cycle while the
// result side keeps up. When out_tready is low the result register holds its
// word, the input register fills, and in_tready drops until the result is
// taken.
// Synchronous reset clears both stages, returns the parser to waiting for
// 'R', sets the distance to 20 cm and the limits to 20 and 800 cm.
// ----------------------------------------------------------------------------
module sonar_range_frame_parser_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] rx_byte
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [15:0]                  out_tdata,  // [9:0] distance_cm, rest zero
  output logic [1:0]                   out_tuser,  // [1:0] status
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [srfp_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [15:0]                  cfg_data
);
  import srfp_pkg::*;

  logic [DistW-1:0] min_r;
  logic [DistW-1:0] max_r;
  srfp_item_t       item;
  logic             take;
  logic [1:0]       status;
  logic [DistW-1:0] range_cm;

  assign cfg_ready = 1'b1;

  // Limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= RESET_MIN;
      max_r <= RESET_MAX;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_DIST: min_r <= cfg_data[DistW-1:0];
        REG_MAX_DIST: max_r <= cfg_data[DistW-1:0];
        default: ;
      endcase
    end
  end

  srfp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .take      (take),
    .item      (item)
  );

  srfp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .take       (take),
    .min_dist   (min_r),
    .max_dist   (max_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (status),
    .out_dist   (range_cm)
  );

  assign out_tuser = status;
  assign out_tdata = {6'd0, range_cm};

endmodule

// File: rtl/srfp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfp_in_stage: input register
// Captures one received byte per cycle and holds it until the parse stage
// takes it.
// ----------------------------------------------------------------------------
module srfp_in_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [srfp_pkg::ByteW-1:0] in_tdata,
  input  logic                      take,
  output srfp_pkg::srfp_item_t      item
);
  import srfp_pkg::*;

  logic             vld_r;
  logic [ByteW-1:0] byte_r;

  // Accept when empty or when the held word leaves this cycle
  assign in_tready = !vld_r || take;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
    end
  end

  assign item.vld     = vld_r;
  assign item.rx_byte = byte_r;

endmodule

// File: rtl/srfp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfp_parse: frame parser and result register
// Advances the frame state on each byte and loads status and last distance
// into the result register.
// ----------------------------------------------------------------------------
module srfp_parse (
  input  logic                       clk,
  input  logic                       rst_n,
  input  srfp_pkg::srfp_item_t       item,
  output logic                       take,
  input  logic [srfp_pkg::DistW-1:0] min_dist,
  input  logic [srfp_pkg::DistW-1:0] max_dist,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [1:0]                 out_status,
  output logic [srfp_pkg::DistW-1:0] out_dist
);
  import srfp_pkg::*;

  logic [1:0]       phase_r, phase_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [DistW-1:0] acc_r, acc_nxt;
  logic [DistW-1:0] dist_r, dist_nxt;
  logic [1:0]       status;
  logic             out_v_r;
  logic [1:0]       status_r;
  logic [DistW-1:0] odist_r;
  logic             is_digit;
  logic [DistW-1:0] acc_x10;
  logic [ByteW-1:0] b;

  // Move a word when the result register is free or being drained
  assign take = item.vld && (!out_v_r || out_tready);

  assign b        = item.rx_byte;
  assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign acc_x10  = {acc_r[6:0], 3'b000} + {acc_r[8:0], 1'b0};

  // Next frame state and status
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    dist_nxt  = dist_r;
    status    = ST_OK;
    unique case (phase_r)
      PH_DIGITS: begin
        if (!is_digit) begin
          phase_nxt = PH_WAIT_R;
          status    = ST_ERR;
        end else begin
          acc_nxt = acc_x10 + {6'd0, b[3:0]};
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_nxt == FRAME_DIGITS) begin
            phase_nxt = PH_CR;
          end
        end
      end
      PH_CR: begin
        if (b != CHAR_CR || cnt_r != FRAME_DIGITS) begin
          status = ST_ERR;
        end else if (acc_r < min_dist || acc_r > max_dist) begin
          status = ST_ERR;
        end else begin
          dist_nxt = acc_r;
          status   = ST_NEW;
        end
        phase_nxt = PH_WAIT_R;
      end
      default: begin
        // Waiting for the lead byte; the unused code decodes the same way
        cnt_nxt = 2'd0;
        acc_nxt = '0;
        if (b == CHAR_R) begin
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_WAIT_R;
          status    = ST_ERR;
        end
      end
    endcase
  end

  // Advance frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT_R;
      cnt_r   <= 2'd0;
      acc_r   <= '0;
      dist_r  <= RESET_DIST;
    end else if (take) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      dist_r  <= dist_nxt;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (take) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      status_r <= status;
      odist_r  <= dist_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_status = status_r;
  assign out_dist   = odist_r;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sonar_range_frame_parser_top
// Streams received bytes into the parser with random gaps on both sides,
// tracks the frame state and distance limits alongside the block, and
// compares every status and distance word with the tracked values. Covers
// the limits after reset, register writes, a long result stall and random
// traffic that is mostly whole frames with some broken frames and noise.
// ----------------------------------------------------------------------------
module testbench;
  import srfp_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 6;
  localparam logic [CfgIdxW-1:0] REG_SPARE = REG_MAX_DIST + 1'b1;

  typedef struct packed {
    logic [1:0]       status;
    logic [DistW-1:0] distance;
  } reading_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;    // [7:0] rx_byte
  logic                 out_tvalid;
  logic                 out_tready;
  logic [15:0]          out_tdata;   // [9:0] distance_cm, rest zero
  logic [1:0]           out_tuser;   // [1:0] status
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [15:0]          cfg_data;

  // Tracked parser state and limits
  logic [1:0]       frame_phase;
  logic [1:0]       frame_digits;
  logic [DistW-1:0] frame_value;
  logic [DistW-1:0] good_distance;
  logic [DistW-1:0] lim_min;
  logic [DistW-1:0] lim_max;

  reading_t pending_readings[$];

  int  error_count;
  int  bytes_sent;
  int  new_seen;
  int  err_seen;
  int  cfg_writes;
  int  cycle_count;
  int  tready_hold;
  int  sink_stall;
  bit  smooth;

  sonar_range_frame_parser_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Gap length: mostly none or short, a few long; none in smooth stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (smooth) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // Advance the tracked parser by one byte and return the expected word
  function automatic reading_t parse_rx_byte(input logic [7:0] rx);
    reading_t res;
    int       acc;
    res.status = ST_OK;
    if (frame_phase == PH_DIGITS) begin
      if (rx < CHAR_ZERO || rx > CHAR_NINE) begin
        frame_phase = PH_WAIT_R;
        res.status  = ST_ERR;
      end else begin
        acc          = int'(frame_value) * 10 + int'(rx - CHAR_ZERO);
        frame_value  = acc[DistW-1:0];
        frame_digits = frame_digits + 2'd1;
        if (frame_digits == FRAME_DIGITS) frame_phase = PH_CR;
      end
    end else if (frame_phase == PH_CR) begin
      if (rx != CHAR_CR || frame_digits != FRAME_DIGITS) begin
        res.status = ST_ERR;
      end else if (frame_value < lim_min || frame_value > lim_max) begin
        res.status = ST_ERR;
      end else begin
        good_distance = frame_value;
        res.status    = ST_NEW;
      end
      frame_phase = PH_WAIT_R;
    end else begin
      // waiting for 'R'; the spare phase code decodes the same way
      frame_digits = 2'd0;
      frame_value  = '0;
      if (rx == CHAR_R) begin
        frame_phase = PH_DIGITS;
      end else begin
        frame_phase = PH_WAIT_R;
        res.status  = ST_ERR;
      end
    end
    res.distance = good_distance;
    return res;
  endfunction

  // Offer one byte after a random gap; valid stays high until released
  task automatic send_byte(input logic [7:0] rx);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rx;
    do @(posedge clk); while (!in_tready);
    pending_readings.push_back(parse_rx_byte(rx));
    bytes_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Send 'R', three digits and CR
  task automatic send_frame(input int unsigned value);
    send_byte(CHAR_R);
    send_byte(CHAR_ZERO + 8'((value / 100) % 10));
    send_byte(CHAR_ZERO + 8'((value / 10) % 10));
    send_byte(CHAR_ZERO + 8'(value % 10));
    send_byte(CHAR_CR);
  endtask

  // Wait until every expected word has come back, then let the pipe settle
  task automatic drain_results();
    release_input();
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Register write; only called while the parser is idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MIN_DIST) lim_min = data[DistW-1:0];
    else if (idx == REG_MAX_DIST) lim_max = data[DistW-1:0];
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write both limits with random bits above the register width
  task automatic set_limits(input int unsigned lo, input int unsigned hi);
    write_reg(REG_MIN_DIST, {6'($urandom_range(0, 63)), 10'(lo)});
    write_reg(REG_MAX_DIST, {6'($urandom_range(0, 63)), 10'(hi)});
  endtask

  // Drive the result side: random stalls plus an optional long hold
  always @(negedge clk) begin
    if (tready_hold > 0) begin
      out_tready <= 1'b0;
      tready_hold = tready_hold - 1;
    end else if (sink_stall > 0) begin
      out_tready <= 1'b0;
      sink_stall = sink_stall - 1;
    end else begin
      sink_stall = pick_gap();
      out_tready <= (sink_stall == 0);
      if (sink_stall > 0) sink_stall = sink_stall - 1;
    end
  end

  // Check each accepted result against the oldest expected word
  always @(posedge clk) begin
    reading_t exp_word;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result status=%0d distance=%0d", $time,
                 out_tuser, out_tdata);
        error_count++;
      end else begin
        exp_word = pending_readings.pop_front();
        if (exp_word.status == ST_NEW) new_seen++;
        if (exp_word.status == ST_ERR) err_seen++;
        if (out_tuser !== exp_word.status) begin
          $display("%0t: status mismatch expected %0d actual %0d", $time,
                   exp_word.status, out_tuser);
          error_count++;
        end
        if (out_tdata !== {6'd0, exp_word.distance}) begin
          $display("%0t: distance mismatch expected %0d actual %0d", $time,
                   exp_word.distance, out_tdata);
          error_count++;
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               pending_readings.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Default limits: good frame, both range errors, bad lead, bad digits,
  // missing CR
  task automatic test_default_limits();
    send_frame(123);
    send_frame(0);
    send_frame(999);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_R);
    send_byte(CHAR_ZERO + 8'd1);
    send_byte(CHAR_ZERO - 8'd1);
    send_byte(CHAR_R);
    send_byte(CHAR_NINE + 8'd1);
    send_byte(CHAR_R);
    send_byte(CHAR_ZERO + 8'd4);
    send_byte(CHAR_ZERO + 8'd5);
    send_byte(CHAR_ZERO + 8'd6);
    send_byte(CHAR_R);
    drain_results();
  endtask

  // Limit extremes: full range, equal limits, min above max, masked data
  task automatic test_limit_extremes();
    set_limits(0, 999);
    send_frame(0);
    send_frame(999);
    drain_results();
    set_limits(345, 345);
    send_frame(345);
    send_frame(344);
    send_frame(346);
    drain_results();
    set_limits(999, 0);
    send_frame(500);
    drain_results();
    write_reg(REG_SPARE, 16'hFFFF);
    write_reg(REG_MIN_DIST, 16'hFC00);
    write_reg(REG_MAX_DIST, 16'hFFFF);
    send_frame(0);
    drain_results();
  endtask

  // Hold the result side for a long stretch while bytes keep coming
  task automatic test_result_stall();
    set_limits(20, 800);
    smooth = 1'b1;
    tready_hold = 80;
    repeat (6) send_frame($urandom_range(0, 999));
    smooth = 1'b0;
    drain_results();
  endtask

  // One random phase: mostly whole frames, some broken frames and noise
  task automatic run_random_phase(input int n_items);
    int start;
    int r;
    int k;
    int unsigned value;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        if ($urandom_range(0, 3) == 0)
          value = (($urandom_range(0, 1) ? int'(lim_min) : int'(lim_max))
                   + $urandom_range(0, 2) + 999) % 1000;
        else
          value = $urandom_range(0, 999);
        send_frame(value);
      end else if (r < 85) begin
        send_byte(CHAR_R);
        k = $urandom_range(0, 3);
        repeat (k) send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)));
        else send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_R);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    drain_results();
  endtask

  // Random traffic under several limit settings
  task automatic test_random_traffic();
    int unsigned lo;
    int unsigned hi;
    for (int ph = 0; ph < 6; ph++) begin
      lo = $urandom_range(0, 999);
      hi = $urandom_range(lo, 999);
      case (ph)
        0: set_limits(0, 999);
        1: set_limits(lo, hi);
        2: set_limits(hi, lo);
        3: begin
          set_limits(lo / 2, hi);
          smooth = 1'b1;
        end
        4: begin
          write_reg(8'($urandom_range(2, 255)), 16'($urandom_range(0, 65535)));
          write_reg(REG_MIN_DIST, 16'($urandom_range(0, 65535)));
          write_reg(REG_MAX_DIST, 16'($urandom_range(0, 65535)));
        end
        default: set_limits(999, 999);
      endcase
      run_random_phase(185);
      smooth = 1'b0;
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    error_count = 0;
    bytes_sent  = 0;
    new_seen    = 0;
    err_seen    = 0;
    cfg_writes  = 0;
    cycle_count = 0;
    tready_hold = 0;
    sink_stall  = 0;
    smooth      = 1'b0;
    frame_phase   = PH_WAIT_R;
    frame_digits  = 2'd0;
    frame_value   = '0;
    good_distance = RESET_DIST;
    lim_min       = RESET_MIN;
    lim_max       = RESET_MAX;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_default_limits();
    test_limit_extremes();
    test_result_stall();
    test_random_traffic();

    $display("Sent %0d bytes and %0d register writes; %0d new readings, %0d errors seen.",
             bytes_sent, cfg_writes, new_seen, err_seen);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
